// ===== rtl/jac_pkg.sv =====
// Shared constants, codes and control types for the joystick axis conditioner.
`timescale 1ns / 1ps

package jac_pkg;

   // ADC and arithmetic widths.
   localparam int ADC_BITS   = 12;
   localparam int ADC_TOP    = (1 << ADC_BITS) - 1;
   localparam int ADC_MID    = ADC_TOP / 2;
   localparam int PERMILLE   = 1000;
   localparam int PERMILLE_W = 10;
   localparam int DB_W       = 11;
   localparam int FS_W       = 15;
   localparam int POS_W      = 16;
   localparam int FAULT_W    = 2;
   localparam int FUNC_W     = 2;

   // Signed edge values need room for center plus or minus the dead band.
   localparam int SPAN_W = ((ADC_BITS > DB_W) ? ADC_BITS : DB_W) + 2;
   localparam int EDGE_W = SPAN_W + 1;

   // Shared divider: two quotient bits per cycle.
   localparam int DVD_W     = 26;
   localparam int DVS_W     = SPAN_W;
   localparam int DIV_STEPS = 2;
   localparam int DIV_ITER  = DVD_W / DIV_STEPS;
   localparam int DIV_CNT_W = $clog2(DIV_ITER);

   // Stream and register port widths.
   localparam int REQ_W      = 16;
   localparam int RSP_W      = 56;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Item function codes.
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CAL_START = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CAL_END   = 2'd2;

   // Fault codes.
   localparam logic [FAULT_W-1:0] FAULT_NONE          = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_NOT_INSTALLED = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_BATTERY       = 2'd2;
   localparam logic [FAULT_W-1:0] FAULT_GROUND        = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_INSTALLED  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAT_LEVEL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GND_LEVEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_BAND  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 3'd4;

   // Configuration reset values.
   localparam logic [ADC_BITS-1:0] RST_BAT_LEVEL  = ADC_BITS'(3900);
   localparam logic [ADC_BITS-1:0] RST_GND_LEVEL  = ADC_BITS'(100);
   localparam logic [DB_W-1:0]     RST_DEAD_BAND  = DB_W'(100);
   localparam logic [FS_W-1:0]     RST_FULL_SCALE = FS_W'(1000);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic prep;
      logic ratio;
      logic square;
      logic scale;
      logic finish;
      logic publish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic compute;
      logic skip;
      logic saturated;
      logic div_done;
   } sts_type;

endpackage

// ===== rtl/jac_divider.sv =====
// Iterative unsigned restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps

module jac_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [jac_pkg::DVD_W-1:0]   dividend,
   input  logic [jac_pkg::DVS_W-1:0]   divisor,
   output logic                        done,
   output logic [jac_pkg::DVD_W-1:0]   quotient
);
   import jac_pkg::*;

   logic [DVS_W:0]     rem_ff, rem_in;
   logic [DVD_W-1:0]   quo_ff, quo_in;
   logic [DVS_W-1:0]   dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic               busy_ff;
   logic               done_ff;

   // Shift in dividend bits and subtract the divisor where it fits.
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         rem_in = {rem_in[DVS_W-1:0], quo_in[DVD_W-1]};
         quo_in = {quo_in[DVD_W-2:0], 1'b0};
         if (rem_in >= {1'b0, dvs_ff}) begin
            rem_in    = rem_in - {1'b0, dvs_ff};
            quo_in[0] = 1'b1;
         end
      end
   end

   // Iteration registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // Iteration count and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_ITER - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // A new division is only started when the unit is free.
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");

   // The last iteration is followed by the completion pulse.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && (cnt_ff == '0) && !start |=> done_ff)
      else $error("divider completion pulse missing");

endmodule

// ===== rtl/jac_datapath.sv =====
// Datapath: configuration, calibration state, deflection arithmetic and result word.
`timescale 1ns / 1ps

module jac_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [jac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jac_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic [jac_pkg::FUNC_W-1:0]       req_tuser,
   input  logic [jac_pkg::REQ_W-1:0]        req_tdata,
   input  jac_pkg::cmd_type                 cmd,
   output jac_pkg::sts_type                 sts,
   output logic [jac_pkg::RSP_W-1:0]        rsp_tdata
);
   import jac_pkg::*;

   // Configuration registers.
   logic                 installed_ff;
   logic [ADC_BITS-1:0]  bat_level_ff;
   logic [ADC_BITS-1:0]  gnd_level_ff;
   logic [DB_W-1:0]      dead_band_ff;
   logic [FS_W-1:0]      full_scale_ff;

   // Calibration and held result state.
   logic [ADC_BITS-1:0]  cal_low_ff, cal_low_in;
   logic [ADC_BITS-1:0]  cal_high_ff, cal_high_in;
   logic [ADC_BITS-1:0]  cal_center_ff, cal_center_in;
   logic                 calibrating_ff, calibrating_in;
   logic [POS_W-1:0]     held_position_ff, held_position_in;
   logic [FAULT_W-1:0]   held_fault_ff, held_fault_in;

   // Working registers for the current word.
   logic [FUNC_W-1:0]        func_ff;
   logic [ADC_BITS-1:0]      sample_ff;
   logic [ADC_BITS-1:0]      v_ff, v_in;
   logic signed [EDGE_W-1:0] up_ff, up_in;
   logic signed [EDGE_W-1:0] dn_ff, dn_in;
   logic                     neg_ff;
   logic                     sat_ff;
   logic [RSP_W-1:0]         rsp_data_ff;

   logic                     over_bat;
   logic                     under_gnd;
   logic signed [EDGE_W-1:0] v_s;
   logic signed [EDGE_W-1:0] span_s;
   logic [DVS_W-1:0]         span_mag;
   logic [ADC_BITS-1:0]      num;
   logic                     upper;
   logic                     lower;
   logic [PERMILLE_W-1:0]    ratio_q;
   logic [PERMILLE_W-1:0]    mag;
   logic [POS_W-1:0]         pos_mag;
   logic                     div_start;
   logic [DVD_W-1:0]         div_dividend;
   logic [DVS_W-1:0]         div_divisor;
   logic                     div_done;
   logic [DVD_W-1:0]         div_quo;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         installed_ff  <= 1'b1;
         bat_level_ff  <= RST_BAT_LEVEL;
         gnd_level_ff  <= RST_GND_LEVEL;
         dead_band_ff  <= RST_DEAD_BAND;
         full_scale_ff <= RST_FULL_SCALE;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INSTALLED:  installed_ff  <= csr_data[0];
            CSR_BAT_LEVEL:  bat_level_ff  <= csr_data[ADC_BITS-1:0];
            CSR_GND_LEVEL:  gnd_level_ff  <= csr_data[ADC_BITS-1:0];
            CSR_DEAD_BAND:  dead_band_ff  <= csr_data[DB_W-1:0];
            CSR_FULL_SCALE: full_scale_ff <= csr_data[FS_W-1:0];
            default: ;
         endcase
      end
   end

   // Fault checks on the captured sample.
   assign over_bat  = sample_ff > bat_level_ff;
   assign under_gnd = sample_ff < gnd_level_ff;

   assign sts.compute = (func_ff == FUNC_SAMPLE) && installed_ff && !over_bat && !under_gnd &&
                        !calibrating_ff;

   // Clamp to the learned range and form both dead band edges.
   always_comb begin
      if (sample_ff < cal_low_ff) begin
         v_in = cal_low_ff;
      end else if (sample_ff > cal_high_ff) begin
         v_in = cal_high_ff;
      end else begin
         v_in = sample_ff;
      end
      up_in = $signed(EDGE_W'(cal_center_ff)) + $signed(EDGE_W'(dead_band_ff));
      dn_in = $signed(EDGE_W'(cal_center_ff)) - $signed(EDGE_W'(dead_band_ff));
   end

   // Side selection, deflection numerator and span magnitude.
   always_comb begin
      v_s   = $signed(EDGE_W'(v_ff));
      upper = v_s > up_ff;
      lower = v_s < dn_ff;
      if (upper) begin
         num    = ADC_BITS'(v_s - up_ff);
         span_s = $signed(EDGE_W'(cal_high_ff)) - up_ff;
      end else begin
         num    = ADC_BITS'(dn_ff - v_s);
         span_s = $signed(EDGE_W'(cal_low_ff)) - dn_ff;
      end
      if (span_s[EDGE_W-1]) begin
         span_mag = DVS_W'(-span_s);
      end else begin
         span_mag = DVS_W'(span_s);
      end
   end

   assign sts.skip = !(upper || lower) || (span_s == '0);

   // A ratio above 1000 squares past the cap, so only the saturation matters.
   assign sts.saturated = div_quo >= DVD_W'(PERMILLE + 1);
   assign ratio_q       = div_quo[PERMILLE_W-1:0];
   assign mag           = sat_ff ? PERMILLE_W'(PERMILLE) : div_quo[PERMILLE_W-1:0];
   assign pos_mag       = div_quo[POS_W-1:0];

   // Divider operand selection for the three divisions of a deflection.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = DVS_W'(PERMILLE);
      if (cmd.ratio) begin
         div_start    = !sts.skip;
         div_dividend = DVD_W'(num) * DVD_W'(PERMILLE);
         div_divisor  = span_mag;
      end else if (cmd.square) begin
         div_start    = !sts.saturated;
         div_dividend = DVD_W'(ratio_q) * DVD_W'(ratio_q);
      end else if (cmd.scale) begin
         div_start    = 1'b1;
         div_dividend = DVD_W'(mag) * DVD_W'(full_scale_ff);
      end
   end

   jac_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign sts.div_done = div_done;

   // Next values of the calibration and held result state.
   always_comb begin
      cal_low_in       = cal_low_ff;
      cal_high_in      = cal_high_ff;
      cal_center_in    = cal_center_ff;
      calibrating_in   = calibrating_ff;
      held_position_in = held_position_ff;
      held_fault_in    = held_fault_ff;
      if (cmd.prep) begin
         case (func_ff)
            FUNC_SAMPLE: begin
               if (!installed_ff) begin
                  held_position_in = '0;
                  held_fault_in    = FAULT_NOT_INSTALLED;
                  cal_low_in       = '0;
                  cal_high_in      = ADC_BITS'(ADC_TOP);
                  cal_center_in    = ADC_BITS'(ADC_MID);
               end else if (over_bat) begin
                  held_position_in = '0;
                  held_fault_in    = FAULT_BATTERY;
               end else if (under_gnd) begin
                  held_position_in = '0;
                  held_fault_in    = FAULT_GROUND;
               end else begin
                  held_fault_in = FAULT_NONE;
                  if (calibrating_ff) begin
                     // Calibration widens the learned range.
                     held_position_in = '0;
                     if (sample_ff > cal_high_ff) begin
                        cal_high_in = sample_ff;
                     end
                     if (sample_ff < cal_low_ff) begin
                        cal_low_in = sample_ff;
                     end
                  end
               end
            end
            FUNC_CAL_START: begin
               if (installed_ff) begin
                  if (!calibrating_ff) begin
                     cal_low_in    = ADC_BITS'(ADC_MID);
                     cal_high_in   = ADC_BITS'(ADC_MID);
                     cal_center_in = sample_ff;
                  end
                  calibrating_in = 1'b1;
               end
            end
            FUNC_CAL_END: begin
               calibrating_in = 1'b0;
            end
            default: ;
         endcase
      end
      if (cmd.ratio && sts.skip) begin
         held_position_in = '0;
      end
      if (cmd.finish) begin
         held_position_in = neg_ff ? -pos_mag : pos_mag;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_low_ff       <= '0;
         cal_high_ff      <= ADC_BITS'(ADC_TOP);
         cal_center_ff    <= ADC_BITS'(ADC_MID);
         calibrating_ff   <= 1'b0;
         held_position_ff <= '0;
         held_fault_ff    <= FAULT_NONE;
      end else begin
         cal_low_ff       <= cal_low_in;
         cal_high_ff      <= cal_high_in;
         cal_center_ff    <= cal_center_in;
         calibrating_ff   <= calibrating_in;
         held_position_ff <= held_position_in;
         held_fault_ff    <= held_fault_in;
      end
   end

   // Working registers for the word in flight.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_tuser;
         sample_ff <= req_tdata[ADC_BITS-1:0];
      end
      if (cmd.prep) begin
         v_ff  <= v_in;
         up_ff <= up_in;
         dn_ff <= dn_in;
      end
      if (cmd.ratio) begin
         neg_ff <= !upper;
      end
      if (cmd.square) begin
         sat_ff <= sts.saturated;
      end
      if (cmd.publish) begin
         rsp_data_ff <= {1'b0, cal_center_ff, cal_high_ff, cal_low_ff, calibrating_ff,
                         held_fault_ff, held_position_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

   // Any fault leaves the held position at zero.
   assert property (@(posedge clock) disable iff (reset)
      (held_fault_ff != FAULT_NONE) |-> (held_position_ff == '0))
      else $error("nonzero position held together with a fault");

endmodule

// ===== rtl/jac_ctrl.sv =====
// Controller: sequences each word through the datapath and owns both handshakes.
`timescale 1ns / 1ps

module jac_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output jac_pkg::cmd_type  cmd,
   input  jac_pkg::sts_type  sts
);
   import jac_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_RATIO,
      ST_DIV_RATIO,
      ST_SQUARE,
      ST_DIV_SQUARE,
      ST_SCALE,
      ST_DIV_SCALE,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Datapath commands decoded from the state.
   always_comb begin
      cmd         = '0;
      cmd.capture = (state_ff == ST_IDLE) && req_tvalid;
      cmd.prep    = (state_ff == ST_PREP);
      cmd.ratio   = (state_ff == ST_RATIO);
      cmd.square  = (state_ff == ST_SQUARE);
      cmd.scale   = (state_ff == ST_SCALE);
      cmd.finish  = (state_ff == ST_FINISH);
      cmd.publish = (state_ff == ST_OUTPUT) && (!rsp_valid_ff || rsp_tready);
   end

   // State and result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A published word raises valid; an accepted word clears it.
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               state_ff <= sts.compute ? ST_RATIO : ST_OUTPUT;
            end
            ST_RATIO: begin
               state_ff <= sts.skip ? ST_OUTPUT : ST_DIV_RATIO;
            end
            ST_DIV_RATIO: begin
               if (sts.div_done) begin
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               state_ff <= sts.saturated ? ST_SCALE : ST_DIV_SQUARE;
            end
            ST_DIV_SQUARE: begin
               if (sts.div_done) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               state_ff <= ST_DIV_SCALE;
            end
            ST_DIV_SCALE: begin
               if (sts.div_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               state_ff <= ST_OUTPUT;
            end
            ST_OUTPUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // An accepted word always goes to the preparation step.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_PREP)
      else $error("accepted word did not enter preparation");

   // At most one datapath command is active at a time.
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("overlapping datapath commands");

   // Division results only arrive while the controller waits for them.
   assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == ST_DIV_RATIO || state_ff == ST_DIV_SQUARE ||
                        state_ff == ST_DIV_SCALE))
      else $error("division completed outside a wait state");

endmodule

// ===== rtl/joystick_axis_conditioner_core.sv =====
// Top level of the joystick axis conditioner.
// A deflection outside the dead band passes through the shared divider three times (twice
// when the ratio saturates) before its result is valid; a dead band or zero span sample
// and a fault or command word bypass the divider.
// Throughput: one word in flight; the next is accepted in the cycle after the result is
// registered, which may still wait for the consumer. Reset is synchronous and active high.
`timescale 1ns / 1ps

module joystick_axis_conditioner_core (
   input  logic                             clock,
   input  logic                             reset,
   // Input words.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [jac_pkg::REQ_W-1:0]        req_tdata,   // sample[11:0], zero padding
   input  logic [jac_pkg::FUNC_W-1:0]       req_tuser,   // func[1:0]
   // Result words.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [jac_pkg::RSP_W-1:0]        rsp_tdata,   // position[15:0], fault[17:16],
                                                         // in_calibration[18],
                                                         // learned_min[30:19],
                                                         // learned_max[42:31],
                                                         // learned_middle[54:43], pad[55]
   // Configuration writes.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [jac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jac_pkg::CSR_DATA_W-1:0]   csr_data
);
   import jac_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   jac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   jac_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule
